// ----- design/debounced_toggle_blink_alarm_core_macros.svh -----
// Assertion macros shared by the RTL; empty when SYNTH is defined.
`ifndef DEBOUNCED_TOGGLE_BLINK_ALARM_CORE_MACROS_SVH
`define DEBOUNCED_TOGGLE_BLINK_ALARM_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication
`define DTBA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define DTBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define DTBA_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define DTBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- design/dtba_pkg.sv -----
package dtba_pkg;

   localparam int unsigned TIME_WIDTH      = 32;
   localparam int unsigned COUNT_WIDTH     = 32;
   localparam int unsigned SAMPLE_WIDTH    = 13;
   localparam int unsigned DEBOUNCE_WIDTH  = 16;
   localparam int unsigned THRESHOLD_WIDTH = 12;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 3;

   localparam int unsigned BLINK_PERIOD_MS_DEFAULT = 1000;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_ENABLED     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BUTTON_ACTIVE_LOW = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_TIME_MS  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALARM_THRESHOLD   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BUTTON_IN_USE     = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LED_IN_USE        = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SENSOR_IN_USE     = 3'd6;

   // Transaction modes
   localparam logic MODE_POLL  = 1'b0;
   localparam logic MODE_CLEAR = 1'b1;

   typedef struct packed {
      logic                           mode;
      logic [TIME_WIDTH-1:0]          time_ms;
      logic                           button_level;
      logic signed [SAMPLE_WIDTH-1:0] sensor_sample;
   } item_type;

   typedef struct packed {
      logic                       block_enabled;
      logic                       button_active_low;
      logic [DEBOUNCE_WIDTH-1:0]  debounce_time_ms;
      logic [THRESHOLD_WIDTH-1:0] alarm_threshold;
      logic                       button_in_use;
      logic                       led_in_use;
      logic                       sensor_in_use;
   } cfg_type;

   typedef struct packed {
      logic                   relay_on;
      logic                   led_on;
      logic                   alarm_on;
      logic [COUNT_WIDTH-1:0] press_total;
   } status_type;

endpackage

// ----- design/dtba_req_if.sv -----
interface dtba_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    mode;
   logic [dtba_pkg::TIME_WIDTH-1:0]         time_ms;
   logic                                    button_level;
   logic signed [dtba_pkg::SAMPLE_WIDTH-1:0] sensor_sample;

   modport source (output valid, mode, time_ms, button_level, sensor_sample,
                   input ready);
   modport sink   (input valid, mode, time_ms, button_level, sensor_sample,
                   output ready);
endinterface

// ----- design/dtba_rsp_if.sv -----
interface dtba_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             relay_on;
   logic                             led_on;
   logic                             alarm_on;
   logic [dtba_pkg::COUNT_WIDTH-1:0] press_total;

   modport source (output valid, relay_on, led_on, alarm_on, press_total,
                   input ready);
   modport sink   (input valid, relay_on, led_on, alarm_on, press_total,
                   output ready);
endinterface

// ----- design/dtba_csr.sv -----
module dtba_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [dtba_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [dtba_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output dtba_pkg::cfg_type                     cfg,
   output logic                                  forget
);

   dtba_pkg::cfg_type cfg_ff, cfg_in;
   logic              hit;

   always_comb begin
      cfg_in = cfg_ff;
      hit    = 1'b0;
      if (csr_we) begin
         hit = 1'b1;
         case (csr_index)
            dtba_pkg::CSR_BLOCK_ENABLED:     cfg_in.block_enabled     = csr_wdata[0];
            dtba_pkg::CSR_BUTTON_ACTIVE_LOW: cfg_in.button_active_low = csr_wdata[0];
            dtba_pkg::CSR_DEBOUNCE_TIME_MS:
               cfg_in.debounce_time_ms = csr_wdata[dtba_pkg::DEBOUNCE_WIDTH-1:0];
            dtba_pkg::CSR_ALARM_THRESHOLD:
               cfg_in.alarm_threshold = csr_wdata[dtba_pkg::THRESHOLD_WIDTH-1:0];
            dtba_pkg::CSR_BUTTON_IN_USE:     cfg_in.button_in_use     = csr_wdata[0];
            dtba_pkg::CSR_LED_IN_USE:        cfg_in.led_in_use        = csr_wdata[0];
            dtba_pkg::CSR_SENSOR_IN_USE:     cfg_in.sensor_in_use     = csr_wdata[0];
            default:                         hit = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_enabled     <= 1'b0;
         cfg_ff.button_active_low <= 1'b1;
         cfg_ff.debounce_time_ms  <= dtba_pkg::DEBOUNCE_WIDTH'(50);
         cfg_ff.alarm_threshold   <= '0;
         cfg_ff.button_in_use     <= 1'b0;
         cfg_ff.led_in_use        <= 1'b0;
         cfg_ff.sensor_in_use     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg    = cfg_ff;
   // a write to a known register drops the debounce history
   assign forget = hit;

endmodule

// ----- design/dtba_step.sv -----
module dtba_step #(
   parameter int unsigned BLINK_PERIOD_MS = dtba_pkg::BLINK_PERIOD_MS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  dtba_pkg::item_type   item,
   input  dtba_pkg::cfg_type    cfg,
   input  logic                 forget,
   output dtba_pkg::status_type status
);

   localparam int unsigned TW = dtba_pkg::TIME_WIDTH;

   logic                           raw_known_ff, raw_known_in;
   logic                           raw_prev_ff, raw_prev_in;
   logic [TW-1:0]                  edge_time_ff, edge_time_in;
   logic                           settled_known_ff, settled_known_in;
   logic                           settled_level_ff, settled_level_in;
   logic [TW-1:0]                  blink_time_ff, blink_time_in;
   logic                           blink_phase_ff, blink_phase_in;
   logic                           led_level_ff, led_level_in;
   logic                           relay_state_ff, relay_state_in;
   logic                           alarm_state_ff, alarm_state_in;
   logic [dtba_pkg::COUNT_WIDTH-1:0] press_counter_ff, press_counter_in;

   logic [TW-1:0] since_edge;
   logic [TW-1:0] since_blink;
   logic          pressed;
   logic          sample_ok;

   assign since_edge  = item.time_ms - edge_time_ff;
   assign since_blink = item.time_ms - blink_time_ff;
   assign pressed     = cfg.button_active_low ? ~item.button_level : item.button_level;
   assign sample_ok   = ~item.sensor_sample[dtba_pkg::SAMPLE_WIDTH-1] &&
      (item.sensor_sample[dtba_pkg::THRESHOLD_WIDTH-1:0] >= cfg.alarm_threshold);

   always_comb begin
      raw_known_in     = raw_known_ff;
      raw_prev_in      = raw_prev_ff;
      edge_time_in     = edge_time_ff;
      settled_known_in = settled_known_ff;
      settled_level_in = settled_level_ff;
      blink_time_in    = blink_time_ff;
      blink_phase_in   = blink_phase_ff;
      led_level_in     = led_level_ff;
      relay_state_in   = relay_state_ff;
      alarm_state_in   = alarm_state_ff;
      press_counter_in = press_counter_ff;

      if (forget) begin
         raw_known_in     = 1'b0;
         settled_known_in = 1'b0;
      end else if (advance) begin
         if (item.mode == dtba_pkg::MODE_CLEAR) begin
            relay_state_in   = 1'b0;
            alarm_state_in   = 1'b0;
            press_counter_in = '0;
            blink_phase_in   = 1'b0;
            raw_known_in     = 1'b0;
            settled_known_in = 1'b0;
         end else if (cfg.block_enabled) begin
            if (cfg.button_in_use) begin
               if (!raw_known_ff || item.button_level != raw_prev_ff) begin
                  raw_known_in = 1'b1;
                  raw_prev_in  = item.button_level;
                  edge_time_in = item.time_ms;
               end else if (since_edge >= TW'(cfg.debounce_time_ms) &&
                            (!settled_known_ff ||
                             item.button_level != settled_level_ff)) begin
                  settled_known_in = 1'b1;
                  settled_level_in = item.button_level;
                  // first settled level is only a baseline
                  if (settled_known_ff && pressed) begin
                     press_counter_in = press_counter_ff + 1'b1;
                     relay_state_in   = ~relay_state_ff;
                  end
               end
            end

            if (cfg.led_in_use) begin
               if (relay_state_in) begin
                  led_level_in = 1'b1;
               end else if (since_blink >= TW'(BLINK_PERIOD_MS)) begin
                  blink_time_in  = item.time_ms;
                  blink_phase_in = ~blink_phase_ff;
                  led_level_in   = ~blink_phase_ff;
               end
            end

            if (cfg.sensor_in_use) begin
               alarm_state_in = sample_ok;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_known_ff     <= 1'b0;
         raw_prev_ff      <= 1'b0;
         edge_time_ff     <= '0;
         settled_known_ff <= 1'b0;
         settled_level_ff <= 1'b0;
         blink_time_ff    <= '0;
         blink_phase_ff   <= 1'b0;
         led_level_ff     <= 1'b0;
         relay_state_ff   <= 1'b0;
         alarm_state_ff   <= 1'b0;
         press_counter_ff <= '0;
      end else begin
         raw_known_ff     <= raw_known_in;
         raw_prev_ff      <= raw_prev_in;
         edge_time_ff     <= edge_time_in;
         settled_known_ff <= settled_known_in;
         settled_level_ff <= settled_level_in;
         blink_time_ff    <= blink_time_in;
         blink_phase_ff   <= blink_phase_in;
         led_level_ff     <= led_level_in;
         relay_state_ff   <= relay_state_in;
         alarm_state_ff   <= alarm_state_in;
         press_counter_ff <= press_counter_in;
      end
   end

   assign status.relay_on    = relay_state_ff;
   assign status.led_on      = led_level_ff;
   assign status.alarm_on    = alarm_state_ff;
   assign status.press_total = press_counter_ff;

endmodule

// ----- design/debounced_toggle_blink_alarm_core.sv -----
// Channel   Dir  Handshake       Payload
// req_if    in   valid / ready   mode, time_ms, button_level, sensor_sample
// rsp_if    out  valid / ready   relay_on, led_on, alarm_on, press_total
// csr_*     in   csr_we          csr_index, csr_wdata (write only)
//
// One transaction per cycle sustained while rsp_if.ready stays high; after the request
// handshake a transaction passes the input register, then the state/result register,
// and rsp_if.valid rises once it lands in the state/result register.
// The state registers are the result register: a transaction moves into them
// only when the previous result has been taken or is being taken.
// A stalled rsp_if backs up into req_if.ready once the input register is full.
// Reset is synchronous and restores state, configuration and valid flags.
`include "debounced_toggle_blink_alarm_core_macros.svh"

module debounced_toggle_blink_alarm_core #(
   parameter int unsigned BLINK_PERIOD_MS = dtba_pkg::BLINK_PERIOD_MS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   dtba_req_if.sink                             req_if,
   dtba_rsp_if.source                           rsp_if,
   input  logic                                 csr_we,
   input  logic [dtba_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dtba_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic                 in_valid_ff, in_valid_in;
   dtba_pkg::item_type   in_item_ff, in_item_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;
   logic                 advance;
   logic                 take;
   dtba_pkg::cfg_type    cfg;
   logic                 forget;
   dtba_pkg::status_type status;

   assign out_free     = ~rsp_valid_ff | rsp_if.ready;
   assign advance      = in_valid_ff & out_free;
   assign req_if.ready = ~in_valid_ff | out_free;
   assign take         = req_if.valid & req_if.ready;

   always_comb begin
      in_valid_in = take | (in_valid_ff & ~advance);
      in_item_in  = in_item_ff;
      if (take) begin
         in_item_in.mode          = req_if.mode;
         in_item_in.time_ms       = req_if.time_ms;
         in_item_in.button_level  = req_if.button_level;
         in_item_in.sensor_sample = req_if.sensor_sample;
      end
      rsp_valid_in = advance | (rsp_valid_ff & ~rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_item_ff <= in_item_in;
   end

   dtba_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .forget    (forget)
   );

   dtba_step #(
      .BLINK_PERIOD_MS (BLINK_PERIOD_MS)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .forget  (forget),
      .status  (status)
   );

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.relay_on    = status.relay_on;
   assign rsp_if.led_on      = status.led_on;
   assign rsp_if.alarm_on    = status.alarm_on;
   assign rsp_if.press_total = status.press_total;

   // A clear transaction leaves relay, alarm and count at zero unless a known register is written alongside it
   `DTBA_ASSERT_NEXT(a_clear_zeroes, clock, reset, advance && in_item_ff.mode == dtba_pkg::MODE_CLEAR, !rsp_if.relay_on && !rsp_if.alarm_on && rsp_if.press_total == '0, "clear did not zero state")

   // Result state holds while no transaction moves into it
   `DTBA_ASSERT_NEXT(a_hold_idle, clock, reset, !advance, $stable(rsp_if.press_total) && $stable(rsp_if.relay_on), "state changed without a transaction")

   // A counted press always toggles the relay
   `DTBA_ASSERT_SAME(a_press_toggles, clock, reset, !$past(reset) && rsp_if.press_total != $past(rsp_if.press_total) && rsp_if.press_total != '0, rsp_if.relay_on != $past(rsp_if.relay_on), "press without relay toggle")

   // Every moved transaction produces a pending result
   `DTBA_ASSERT_NEXT(a_result_pending, clock, reset, advance, rsp_if.valid, "result lost")

endmodule

// ----- tb/tb_debounced_toggle_blink_alarm_core.sv -----
`timescale 1ns / 1ps

module tb_debounced_toggle_blink_alarm_core;

   localparam logic [dtba_pkg::CSR_INDEX_WIDTH-1:0] UNMAPPED_INDEX = 3'd7;
   localparam int unsigned ITEMS_PER_SETTING = 200;
   localparam int unsigned SETTING_COUNT = 8;
   localparam int unsigned HOLD_CYCLES = 300;

   class toggle_alarm_model;
      dtba_pkg::cfg_type cfg;
      bit raw_seen;
      bit raw_last;
      bit level_seen;
      bit level_stable;
      logic [dtba_pkg::TIME_WIDTH-1:0] raw_change_ms;
      logic [dtba_pkg::TIME_WIDTH-1:0] blink_mark_ms;
      bit blink_toggle;
      bit led_drive;
      bit relay_drive;
      bit alarm_drive;
      logic [dtba_pkg::COUNT_WIDTH-1:0] press_count;
      dtba_pkg::status_type pending_status[$];
      int mismatches;
      int matched;
      int toggles;

      function new();
         cfg.block_enabled = 1'b0;
         cfg.button_active_low = 1'b1;
         cfg.debounce_time_ms = 16'd50;
         cfg.alarm_threshold = '0;
         cfg.button_in_use = 1'b0;
         cfg.led_in_use = 1'b0;
         cfg.sensor_in_use = 1'b0;
         raw_change_ms = '0;
         blink_mark_ms = '0;
         press_count = '0;
      endfunction

      function int pending();
         return pending_status.size();
      endfunction

      function void write_register(logic [dtba_pkg::CSR_INDEX_WIDTH-1:0] idx,
                                   logic [dtba_pkg::CSR_DATA_WIDTH-1:0] data);
         case (idx)
            dtba_pkg::CSR_BLOCK_ENABLED:     cfg.block_enabled = data[0];
            dtba_pkg::CSR_BUTTON_ACTIVE_LOW: cfg.button_active_low = data[0];
            dtba_pkg::CSR_DEBOUNCE_TIME_MS:
               cfg.debounce_time_ms = data[dtba_pkg::DEBOUNCE_WIDTH-1:0];
            dtba_pkg::CSR_ALARM_THRESHOLD:
               cfg.alarm_threshold = data[dtba_pkg::THRESHOLD_WIDTH-1:0];
            dtba_pkg::CSR_BUTTON_IN_USE:     cfg.button_in_use = data[0];
            dtba_pkg::CSR_LED_IN_USE:        cfg.led_in_use = data[0];
            dtba_pkg::CSR_SENSOR_IN_USE:     cfg.sensor_in_use = data[0];
            default:                         return;
         endcase
         // a write to a known register drops the debounce history
         raw_seen = 1'b0;
         level_seen = 1'b0;
      endfunction

      function void take_tick(dtba_pkg::item_type it);
         logic [dtba_pkg::TIME_WIDTH-1:0] since;
         bit pressed;
         dtba_pkg::status_type want;
         if (it.mode == dtba_pkg::MODE_CLEAR) begin
            relay_drive = 1'b0;
            alarm_drive = 1'b0;
            press_count = '0;
            blink_toggle = 1'b0;
            raw_seen = 1'b0;
            level_seen = 1'b0;
         end else if (cfg.block_enabled) begin
            if (cfg.button_in_use) begin
               since = it.time_ms - raw_change_ms;
               if (!raw_seen || it.button_level != raw_last) begin
                  raw_seen = 1'b1;
                  raw_last = it.button_level;
                  raw_change_ms = it.time_ms;
               end else if (since >= cfg.debounce_time_ms &&
                            (!level_seen || it.button_level != level_stable)) begin
                  pressed = cfg.button_active_low ? !it.button_level : it.button_level;
                  // first settled level is only a baseline
                  if (level_seen && pressed) begin
                     press_count = press_count + 1'b1;
                     relay_drive = !relay_drive;
                     toggles++;
                  end
                  level_seen = 1'b1;
                  level_stable = it.button_level;
               end
            end
            if (cfg.led_in_use) begin
               since = it.time_ms - blink_mark_ms;
               if (relay_drive) begin
                  led_drive = 1'b1;
               end else if (since >= dtba_pkg::BLINK_PERIOD_MS_DEFAULT) begin
                  blink_mark_ms = it.time_ms;
                  blink_toggle = !blink_toggle;
                  led_drive = blink_toggle;
               end
            end
            if (cfg.sensor_in_use)
               alarm_drive = !it.sensor_sample[dtba_pkg::SAMPLE_WIDTH-1] &&
                             (it.sensor_sample[dtba_pkg::THRESHOLD_WIDTH-1:0] >=
                              cfg.alarm_threshold);
         end
         want.relay_on = relay_drive;
         want.led_on = led_drive;
         want.alarm_on = alarm_drive;
         want.press_total = press_count;
         pending_status.push_back(want);
      endfunction

      function void report_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         end
      endfunction

      function void match_status(dtba_pkg::status_type got);
         dtba_pkg::status_type want;
         if (pending_status.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected status transaction, expected none got %p",
                     $time, got);
         end else begin
            want = pending_status.pop_front();
            report_field("relay_on", want.relay_on, got.relay_on);
            report_field("led_on", want.led_on, got.led_on);
            report_field("alarm_on", want.alarm_on, got.alarm_on);
            report_field("press_total", want.press_total, got.press_total);
            matched++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [dtba_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [dtba_pkg::CSR_DATA_WIDTH-1:0] csr_wdata;

   dtba_req_if req_if();
   dtba_rsp_if rsp_if();

   debounced_toggle_blink_alarm_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   toggle_alarm_model model = new();
   bit steady_phase;
   bit held_level;
   logic [dtba_pkg::TIME_WIDTH-1:0] now_ms;
   int settings_count;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            model.take_tick({req_if.mode, req_if.time_ms, req_if.button_level,
                             req_if.sensor_sample});
         if (rsp_if.valid && rsp_if.ready)
            model.match_status({rsp_if.relay_on, rsp_if.led_on, rsp_if.alarm_on,
                                rsp_if.press_total});
      end
   end

   // result side: random back-pressure plus one long hold that fills the block
   initial begin : rsp_sink
      int hold_left;
      bit held_once;
      hold_left = 0;
      held_once = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (!held_once && model.matched >= 500) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= steady_phase || ($urandom_range(0, 99) >= 8);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_item(input dtba_pkg::item_type it);
      if (!steady_phase && $urandom_range(0, 99) < 8) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.mode          <= it.mode;
      req_if.time_ms       <= it.time_ms;
      req_if.button_level  <= it.button_level;
      req_if.sensor_sample <= it.sensor_sample;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_poll(input logic [dtba_pkg::TIME_WIDTH-1:0] step, input logic lvl,
                            input logic [dtba_pkg::SAMPLE_WIDTH-1:0] sample);
      dtba_pkg::item_type it;
      now_ms = now_ms + step;
      it.mode = dtba_pkg::MODE_POLL;
      it.time_ms = now_ms;
      it.button_level = lvl;
      it.sensor_sample = sample;
      send_item(it);
   endtask

   task automatic send_clear();
      dtba_pkg::item_type it;
      it.mode = dtba_pkg::MODE_CLEAR;
      it.time_ms = $urandom;
      it.button_level = $urandom_range(0, 1);
      it.sensor_sample = dtba_pkg::SAMPLE_WIDTH'($urandom);
      send_item(it);
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_if.valid <= 1'b0;
      // let the monitor note the last accepted transaction first
      @(posedge clock);
      while (model.pending() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [dtba_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [dtba_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      model.write_register(idx, data);
   endtask

   // upper bits are random so the width masking is exercised too
   task automatic program_registers(input bit en, input bit al,
                                    input logic [dtba_pkg::DEBOUNCE_WIDTH-1:0] deb,
                                    input logic [dtba_pkg::THRESHOLD_WIDTH-1:0] thr,
                                    input bit bu, input bit lu, input bit su);
      wait_drained();
      write_reg(dtba_pkg::CSR_BLOCK_ENABLED, {15'($urandom), en});
      write_reg(dtba_pkg::CSR_BUTTON_ACTIVE_LOW, {15'($urandom), al});
      write_reg(dtba_pkg::CSR_DEBOUNCE_TIME_MS, deb);
      write_reg(dtba_pkg::CSR_ALARM_THRESHOLD, {4'($urandom), thr});
      write_reg(dtba_pkg::CSR_BUTTON_IN_USE, {15'($urandom), bu});
      write_reg(dtba_pkg::CSR_LED_IN_USE, {15'($urandom), lu});
      write_reg(dtba_pkg::CSR_SENSOR_IN_USE, {15'($urandom), su});
      write_reg(UNMAPPED_INDEX, 16'($urandom));
      csr_we <= 1'b0;
      settings_count++;
   endtask

   function automatic logic [dtba_pkg::SAMPLE_WIDTH-1:0] pick_sample(
      logic [dtba_pkg::THRESHOLD_WIDTH-1:0] thr);
      int r;
      int near;
      r = $urandom_range(0, 99);
      if (r < 40) return dtba_pkg::SAMPLE_WIDTH'($urandom_range(0, 4095));
      if (r < 60) begin
         near = int'(thr) + int'($urandom_range(0, 4)) - 2;
         if (near < 0) near = 0;
         if (near > 4095) near = 4095;
         return dtba_pkg::SAMPLE_WIDTH'(near);
      end
      if (r < 70) return '1;
      if (r < 78) return {1'b1, 12'($urandom)};
      if (r < 89) return '0;
      return dtba_pkg::SAMPLE_WIDTH'(4095);
   endfunction

   initial begin
      int n;
      int r;
      logic [dtba_pkg::TIME_WIDTH-1:0] step;
      logic [dtba_pkg::DEBOUNCE_WIDTH-1:0] deb;
      logic lvl;

      reset     <= 1'b1;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_if.valid         <= 1'b0;
      req_if.mode          <= dtba_pkg::MODE_POLL;
      req_if.time_ms       <= '0;
      req_if.button_level  <= 1'b0;
      req_if.sensor_sample <= '0;
      now_ms = '0;
      steady_phase = 1'b0;
      held_level = 1'b1;
      settings_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: block disabled, clear still acts
      send_poll(32'd100, 1'b0, dtba_pkg::SAMPLE_WIDTH'(4095));
      send_clear();

      program_registers(1'b1, 1'b1, 16'd5, 12'd2048, 1'b1, 1'b1, 1'b1);
      now_ms = '0;
      send_poll(32'd0, 1'b1, dtba_pkg::SAMPLE_WIDTH'(4095));
      send_poll(32'd10, 1'b1, '1);
      send_poll(32'd1, 1'b0, dtba_pkg::SAMPLE_WIDTH'(2048));
      send_poll(32'd3, 1'b0, dtba_pkg::SAMPLE_WIDTH'(2047));
      send_poll(32'd2, 1'b0, '0);
      send_poll(32'd1, 1'b1, {1'b1, 12'd0});
      send_poll(32'd6, 1'b1, dtba_pkg::SAMPLE_WIDTH'(4095));
      send_poll(32'd1, 1'b0, dtba_pkg::SAMPLE_WIDTH'(100));
      send_poll(32'd20, 1'b0, dtba_pkg::SAMPLE_WIDTH'(100));
      send_poll(32'd1000, 1'b1, dtba_pkg::SAMPLE_WIDTH'(3000));
      send_poll(32'd999, 1'b1, dtba_pkg::SAMPLE_WIDTH'(3000));
      send_poll(32'd1, 1'b1, dtba_pkg::SAMPLE_WIDTH'(3000));
      send_clear();
      send_poll(32'd0, 1'b0, dtba_pkg::SAMPLE_WIDTH'(1));
      send_poll(32'd9, 1'b0, dtba_pkg::SAMPLE_WIDTH'(1));
      // cross the 32-bit time wrap
      now_ms = '1;
      send_poll(32'd0, 1'b1, dtba_pkg::SAMPLE_WIDTH'(2049));
      send_poll(32'd10, 1'b1, dtba_pkg::SAMPLE_WIDTH'(2049));
      send_poll(32'd3, 1'b0, {1'b1, 12'hFFF});
      send_poll(32'd5, 1'b0, dtba_pkg::SAMPLE_WIDTH'(2049));

      for (int ph = 0; ph < SETTING_COUNT; ph++) begin
         case (ph)
            0: program_registers(1'b1, 1'b0, 16'd0, 12'd0, 1'b1, 1'b1, 1'b1);
            1: program_registers(1'b1, 1'b1, 16'hFFFF, 12'hFFF, 1'b1, 1'b1, 1'b1);
            2: program_registers(1'b0, 1'($urandom), 16'($urandom_range(0, 60)),
                                 12'($urandom), 1'b1, 1'b1, 1'b1);
            6: program_registers(1'b1, 1'($urandom), 16'($urandom_range(0, 60)),
                                 12'($urandom), 1'b1, 1'b0, 1'b1);
            7: program_registers(1'b1, 1'($urandom), 16'($urandom_range(0, 60)),
                                 12'($urandom), 1'b0, 1'b1, 1'b0);
            default: begin
               deb = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                     16'($urandom_range(0, 60));
               program_registers(($urandom_range(0, 5) != 0), 1'($urandom), deb,
                                 12'($urandom), ($urandom_range(0, 3) != 0),
                                 ($urandom_range(0, 3) != 0),
                                 ($urandom_range(0, 3) != 0));
            end
         endcase
         steady_phase = (ph == 3);
         if (ph == 4) now_ms = 32'hFFFF_F000;
         deb = model.cfg.debounce_time_ms;
         for (n = 0; n < ITEMS_PER_SETTING; n++) begin
            // sender pause: let every outstanding result come back
            if (ph == 5 && n == ITEMS_PER_SETTING / 2) wait_drained();
            r = $urandom_range(0, 99);
            if (r < 3) begin
               send_clear();
            end else begin
               r = $urandom_range(0, 99);
               if (r < 80) step = $urandom_range(0, (deb >> 2) + 12);
               else if (r < 92) step = $urandom_range(0, 1500);
               else if (r < 97) step = '0;
               else step = $urandom;
               if ($urandom_range(0, 99) < 8) held_level = !held_level;
               // occasional bounce around the held level
               lvl = ($urandom_range(0, 99) < 15) ? 1'($urandom) : held_level;
               send_poll(step, lvl, pick_sample(model.cfg.alarm_threshold));
            end
         end
      end
      steady_phase = 1'b0;

      wait_drained();
      if (model.pending() != 0) begin
         $display("%0t: %0d expected status transactions never arrived",
                  $time, model.pending());
         model.mismatches += model.pending();
      end
      $display("Run covered %0d status transactions over %0d register settings",
               model.matched, settings_count);
      $display("Relay toggled %0d times; long result hold and sender drain included",
               model.toggles);
      if (model.mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
